FILE: rtl/ffca_pkg.sv
// Shared constants, header layout and control codes of the first-fit chunk allocator.
package ffca_pkg;

  localparam int unsigned BufferBytes   = 65536;
  localparam int unsigned HeaderBytes   = 24;
  localparam int unsigned MinSplitBytes = 64;
  localparam int unsigned GranBytes     = 8;
  localparam int unsigned HdrBytes      = ((HeaderBytes + GranBytes - 1) / GranBytes) * GranBytes;
  localparam int unsigned HdrGran       = HdrBytes / GranBytes;
  localparam int unsigned Granules      = BufferBytes / GranBytes;
  localparam int unsigned GW            = $clog2(Granules);
  localparam int unsigned MaxBytes      = (Granules * GranBytes > 65536) ?
                                          Granules * GranBytes : 65536;
  localparam int unsigned SzW           = $clog2(MaxBytes + 1);
  localparam int unsigned OffW          = 16;

  typedef struct packed {
    logic           start;
    logic [SzW-1:0] size;
    logic           free;
    logic           has_prev;
    logic           has_next;
    logic [GW-1:0]  prev;
    logic [GW-1:0]  next;
  } hdr_t;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_SHRINK = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADOFF  = 2'd2,
    ST_GROW    = 2'd3
  } st_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_RD_HINT,
    OP_PICK,
    OP_WALK,
    OP_RD_OFF,
    OP_LOAD_C,
    OP_SPLIT_CALC,
    OP_WR_N,
    OP_WR_C,
    OP_WR_X,
    OP_RD_X,
    OP_RD_CNEXT,
    OP_RD_CPREV,
    OP_RD_NNEXT,
    OP_XPREV,
    OP_MERGE_CX,
    OP_MERGE_PC,
    OP_MERGE_NX,
    OP_LOAD_HH,
    OP_HINT_ALLOC,
    OP_HINT_SHR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   st_we;
    st_e    st;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic range_ok;
    logic rd_start;
    logic rd_fit;
    logic rd_hn;
    logic rd_free;
    logic rd_grow;
    logic hc_hn;
    logic hc_hp;
    logic split;
    logic old_hn;
    logic nh_hn;
    logic clr_last;
  } flags_t;

endpackage

FILE: rtl/ffca_dp.sv
// Datapath of the chunk allocator: header memory, working registers and hint.
module ffca_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffca_pkg::cmd_t              cmd_i,
  input  logic [1:0]                  req_type_i,
  input  logic [15:0]                 data_offset_i,
  input  logic [15:0]                 req_size_i,
  output ffca_pkg::flags_t            flags_o,
  output logic [1:0]                  status_o,
  output logic [ffca_pkg::OffW-1:0]   result_offset_o
);

  localparam int unsigned GW  = ffca_pkg::GW;
  localparam int unsigned SzW = ffca_pkg::SzW;

  ffca_pkg::hdr_t mem [ffca_pkg::Granules];

  ffca_pkg::hdr_t rdata_q;
  logic           rd_en;
  logic [GW-1:0]  rd_addr;
  logic           we;
  logic [GW-1:0]  wr_addr;
  ffca_pkg::hdr_t wr_data;

  ffca_pkg::req_e type_q, type_d;
  logic [SzW-1:0] size_q, size_d;
  logic [GW-1:0]  off_q, off_d;
  logic           range_q, range_d;
  logic [GW-1:0]  c_q, c_d;
  logic [GW-1:0]  cur_q, cur_d;
  logic [GW-1:0]  n_q, n_d;
  logic [GW-1:0]  x_q, x_d;
  logic [GW-1:0]  lnk_q, lnk_d;
  logic [GW-1:0]  hint_q, hint_d;
  logic [GW-1:0]  clr_q, clr_d;
  ffca_pkg::hdr_t hc_q, hc_d;
  ffca_pkg::hdr_t nh_q, nh_d;
  ffca_pkg::hdr_t xh_q, xh_d;
  logic [SzW-1:0] hh_size_q, hh_size_d;
  logic           split_q, split_d;
  logic           old_hn_q, old_hn_d;
  ffca_pkg::st_e  st_q, st_d;
  logic [ffca_pkg::OffW-1:0] res_q, res_d;

  logic [SzW-1:0] unused;
  logic           do_split;
  logic [GW-1:0]  n_calc;
  logic [SzW-1:0] rnd;
  logic [15:0]    rel;
  logic [31:0]    off32;
  ffca_pkg::hdr_t init_hdr;

  always_comb begin
    unused   = hc_q.size - size_q;
    do_split = (unused >= SzW'(ffca_pkg::MinSplitBytes)) &&
               (unused >= SzW'(ffca_pkg::HdrBytes));
    n_calc   = c_q + GW'(ffca_pkg::HdrGran) + GW'(size_q >> 3);
    rnd      = (SzW'(req_size_i) + SzW'(7)) & ~SzW'(7);
    rel      = data_offset_i - 16'(ffca_pkg::HdrBytes);
    off32    = (32'(c_q) << 3) + 32'(ffca_pkg::HdrBytes);
    init_hdr = '0;
    if (clr_q == '0) begin
      init_hdr.start = 1'b1;
      init_hdr.free  = 1'b1;
      init_hdr.size  = SzW'(ffca_pkg::Granules * ffca_pkg::GranBytes - ffca_pkg::HdrBytes);
    end
  end

  always_comb begin
    flags_o.req      = type_q;
    flags_o.range_ok = range_q;
    flags_o.rd_start = rdata_q.start;
    flags_o.rd_fit   = rdata_q.free && (rdata_q.size >= size_q);
    flags_o.rd_hn    = rdata_q.has_next;
    flags_o.rd_free  = rdata_q.free;
    flags_o.rd_grow  = size_q > rdata_q.size;
    flags_o.hc_hn    = hc_q.has_next;
    flags_o.hc_hp    = hc_q.has_prev;
    flags_o.split    = split_q;
    flags_o.old_hn   = old_hn_q;
    flags_o.nh_hn    = nh_q.has_next;
    flags_o.clr_last = clr_q == GW'(ffca_pkg::Granules - 1);
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = '0;
    wr_data   = rdata_q;
    type_d    = type_q;
    size_d    = size_q;
    off_d     = off_q;
    range_d   = range_q;
    c_d       = c_q;
    cur_d     = cur_q;
    n_d       = n_q;
    x_d       = x_q;
    lnk_d     = lnk_q;
    hint_d    = hint_q;
    clr_d     = clr_q;
    hc_d      = hc_q;
    nh_d      = nh_q;
    xh_d      = xh_q;
    hh_size_d = hh_size_q;
    split_d   = split_q;
    old_hn_d  = old_hn_q;
    unique case (cmd_i.op)
      ffca_pkg::OP_NONE: ;
      ffca_pkg::OP_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_q;
        wr_data = init_hdr;
        clr_d   = clr_q + GW'(1);
      end
      ffca_pkg::OP_CAPTURE: begin
        type_d  = ffca_pkg::req_e'(req_type_i);
        size_d  = rnd;
        off_d   = GW'(rel >> 3);
        range_d = (data_offset_i >= 16'(ffca_pkg::HdrBytes)) && (rel[2:0] == 3'd0) &&
                  (32'(rel >> 3) < 32'(ffca_pkg::Granules));
      end
      ffca_pkg::OP_RD_HINT: begin
        rd_en   = 1'b1;
        rd_addr = hint_q;
      end
      ffca_pkg::OP_PICK: begin
        cur_d   = flags_o.rd_fit ? hint_q : '0;
        rd_en   = 1'b1;
        rd_addr = cur_d;
      end
      ffca_pkg::OP_WALK: begin
        c_d     = cur_q;
        hc_d    = rdata_q;
        cur_d   = rdata_q.next;
        rd_en   = 1'b1;
        rd_addr = rdata_q.next;
      end
      ffca_pkg::OP_RD_OFF: begin
        rd_en   = 1'b1;
        rd_addr = off_q;
      end
      ffca_pkg::OP_LOAD_C: begin
        c_d  = off_q;
        hc_d = rdata_q;
        if (type_q == ffca_pkg::REQ_FREE) begin
          hc_d.free = 1'b1;
        end
      end
      ffca_pkg::OP_SPLIT_CALC: begin
        n_d              = n_calc;
        nh_d.start       = 1'b1;
        nh_d.size        = unused - SzW'(ffca_pkg::HdrBytes);
        nh_d.free        = 1'b1;
        nh_d.has_prev    = 1'b1;
        nh_d.has_next    = hc_q.has_next;
        nh_d.prev        = c_q;
        nh_d.next        = hc_q.next;
        lnk_d            = n_calc;
        x_d              = hc_q.next;
        old_hn_d         = hc_q.has_next;
        split_d          = do_split;
        if (do_split) begin
          hc_d.has_next = 1'b1;
          hc_d.next     = n_calc;
          hc_d.size     = size_q;
        end
        if (type_q == ffca_pkg::REQ_ALLOC) begin
          hc_d.free = 1'b0;
        end
      end
      ffca_pkg::OP_WR_N: begin
        we      = 1'b1;
        wr_addr = n_q;
        wr_data = nh_q;
      end
      ffca_pkg::OP_WR_C: begin
        we      = 1'b1;
        wr_addr = c_q;
        wr_data = hc_q;
      end
      ffca_pkg::OP_WR_X: begin
        we      = 1'b1;
        wr_addr = x_q;
        wr_data = xh_q;
      end
      ffca_pkg::OP_RD_X: begin
        rd_en   = 1'b1;
        rd_addr = x_q;
      end
      ffca_pkg::OP_RD_CNEXT: begin
        x_d     = hc_q.next;
        rd_en   = 1'b1;
        rd_addr = hc_q.next;
      end
      ffca_pkg::OP_RD_CPREV: begin
        x_d     = hc_q.prev;
        rd_en   = 1'b1;
        rd_addr = hc_q.prev;
      end
      ffca_pkg::OP_RD_NNEXT: begin
        x_d     = nh_q.next;
        rd_en   = 1'b1;
        rd_addr = nh_q.next;
      end
      ffca_pkg::OP_XPREV: begin
        we           = 1'b1;
        wr_addr      = x_q;
        wr_data      = rdata_q;
        wr_data.prev = lnk_q;
      end
      ffca_pkg::OP_MERGE_CX: begin
        hc_d.size     = hc_q.size + rdata_q.size + SzW'(ffca_pkg::HdrBytes);
        hc_d.has_next = rdata_q.has_next;
        hc_d.next     = rdata_q.next;
        lnk_d         = c_q;
        we            = 1'b1;
        wr_addr       = x_q;
        wr_data       = rdata_q;
        wr_data.start = 1'b0;
        if (hint_q == x_q) begin
          hint_d = c_q;
        end
      end
      ffca_pkg::OP_MERGE_PC: begin
        xh_d          = rdata_q;
        xh_d.size     = rdata_q.size + hc_q.size + SzW'(ffca_pkg::HdrBytes);
        xh_d.has_next = hc_q.has_next;
        xh_d.next     = hc_q.next;
        lnk_d         = x_q;
        we            = 1'b1;
        wr_addr       = c_q;
        wr_data       = hc_q;
        wr_data.start = 1'b0;
        if (hint_q == c_q) begin
          hint_d = x_q;
        end
      end
      ffca_pkg::OP_MERGE_NX: begin
        nh_d.size     = nh_q.size + rdata_q.size + SzW'(ffca_pkg::HdrBytes);
        nh_d.has_next = rdata_q.has_next;
        nh_d.next     = rdata_q.next;
        we            = 1'b1;
        wr_addr       = x_q;
        wr_data       = rdata_q;
        wr_data.start = 1'b0;
        if (hint_q == x_q) begin
          hint_d = n_q;
        end
      end
      ffca_pkg::OP_LOAD_HH: begin
        hh_size_d = rdata_q.size;
        rd_en     = 1'b1;
        rd_addr   = hc_q.next;
      end
      ffca_pkg::OP_HINT_ALLOC: begin
        if (hc_q.has_next && (rdata_q.size > hh_size_q)) begin
          hint_d = hc_q.next;
        end
      end
      ffca_pkg::OP_HINT_SHR: begin
        if (!rdata_q.free || (hc_q.size > rdata_q.size)) begin
          hint_d = c_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d  = st_q;
    res_d = res_q;
    if (cmd_i.st_we) begin
      st_d  = cmd_i.st;
      res_d = ((cmd_i.st == ffca_pkg::ST_OK) && (type_q == ffca_pkg::REQ_ALLOC)) ?
              off32[ffca_pkg::OffW-1:0] : '0;
    end
  end

  // The header memory has one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    size_q    <= size_d;
    off_q     <= off_d;
    range_q   <= range_d;
    c_q       <= c_d;
    cur_q     <= cur_d;
    n_q       <= n_d;
    x_q       <= x_d;
    lnk_q     <= lnk_d;
    hc_q      <= hc_d;
    nh_q      <= nh_d;
    xh_q      <= xh_d;
    hh_size_q <= hh_size_d;
    split_q   <= split_d;
    old_hn_q  <= old_hn_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q <= '0;
      clr_q  <= '0;
      st_q   <= ffca_pkg::ST_OK;
    end else begin
      hint_q <= hint_d;
      clr_q  <= clr_d;
      st_q   <= st_d;
    end
  end

  assign status_o        = 2'(st_q);
  assign result_offset_o = res_q;

endmodule

FILE: rtl/ffca_ctrl.sv
// Controller of the chunk allocator: sequences header reads and writes per request.
module ffca_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ffca_pkg::flags_t flags_i,
  output ffca_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_A_PICK,
    S_A_WALK,
    S_CHK,
    S_SPLIT,
    S_SPLIT_BR,
    S_A_RDX,
    S_A_XPREV,
    S_A_WRC,
    S_A_RDH,
    S_A_LDH,
    S_A_HUPD,
    S_S_MRG,
    S_S_MRG2,
    S_S_XPREV,
    S_S_WRN,
    S_S_WRC,
    S_S_HINT,
    S_S_HUPD,
    S_F_NXT,
    S_F_MNX,
    S_F_MNX2,
    S_F_XPREV,
    S_F_PRV,
    S_F_MPV,
    S_F_WRX,
    S_F_RDN,
    S_F_XPREV2,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   done_q;

  function automatic ffca_pkg::cmd_t mk(input ffca_pkg::dp_op_e op);
    ffca_pkg::cmd_t c;
    c.op    = op;
    c.st_we = 1'b0;
    c.st    = ffca_pkg::ST_OK;
    return c;
  endfunction

  function automatic ffca_pkg::cmd_t fin(input ffca_pkg::dp_op_e op, input ffca_pkg::st_e st);
    ffca_pkg::cmd_t c;
    c.op    = op;
    c.st_we = 1'b1;
    c.st    = st;
    return c;
  endfunction

  always_comb begin
    state_d = state_q;
    cmd_o   = mk(ffca_pkg::OP_NONE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = mk(ffca_pkg::OP_CLEAR);
        if (flags_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = mk(ffca_pkg::OP_CAPTURE);
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (flags_i.req)
          ffca_pkg::REQ_ALLOC: begin
            cmd_o   = mk(ffca_pkg::OP_RD_HINT);
            state_d = S_A_PICK;
          end
          ffca_pkg::REQ_FREE, ffca_pkg::REQ_SHRINK: begin
            if (flags_i.range_ok) begin
              cmd_o   = mk(ffca_pkg::OP_RD_OFF);
              state_d = S_CHK;
            end else begin
              cmd_o   = fin(ffca_pkg::OP_NONE, ffca_pkg::ST_BADOFF);
              state_d = S_DONE;
            end
          end
          default: begin
            cmd_o   = fin(ffca_pkg::OP_NONE, ffca_pkg::ST_OK);
            state_d = S_DONE;
          end
        endcase
      end
      S_A_PICK: begin
        cmd_o   = mk(ffca_pkg::OP_PICK);
        state_d = S_A_WALK;
      end
      S_A_WALK: begin
        priority if (flags_i.rd_fit) begin
          cmd_o   = mk(ffca_pkg::OP_WALK);
          state_d = S_SPLIT;
        end else if (!flags_i.rd_hn) begin
          cmd_o   = fin(ffca_pkg::OP_NONE, ffca_pkg::ST_NOSPACE);
          state_d = S_DONE;
        end else begin
          cmd_o = mk(ffca_pkg::OP_WALK);
        end
      end
      S_CHK: begin
        cmd_o = mk(ffca_pkg::OP_LOAD_C);
        priority if (!flags_i.rd_start) begin
          cmd_o   = fin(ffca_pkg::OP_NONE, ffca_pkg::ST_BADOFF);
          state_d = S_DONE;
        end else if (flags_i.req == ffca_pkg::REQ_FREE) begin
          state_d = S_F_NXT;
        end else if (flags_i.rd_grow) begin
          cmd_o   = fin(ffca_pkg::OP_NONE, ffca_pkg::ST_GROW);
          state_d = S_DONE;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd_o   = mk(ffca_pkg::OP_SPLIT_CALC);
        state_d = S_SPLIT_BR;
      end
      S_SPLIT_BR: begin
        if (flags_i.req == ffca_pkg::REQ_ALLOC) begin
          priority if (!flags_i.split) begin
            state_d = S_A_WRC;
          end else if (flags_i.old_hn) begin
            cmd_o   = mk(ffca_pkg::OP_WR_N);
            state_d = S_A_RDX;
          end else begin
            cmd_o   = mk(ffca_pkg::OP_WR_N);
            state_d = S_A_WRC;
          end
        end else begin
          priority if (!flags_i.split) begin
            state_d = S_S_HINT;
          end else if (flags_i.old_hn) begin
            cmd_o   = mk(ffca_pkg::OP_RD_X);
            state_d = S_S_MRG;
          end else begin
            state_d = S_S_WRN;
          end
        end
      end
      S_A_RDX: begin
        cmd_o   = mk(ffca_pkg::OP_RD_X);
        state_d = S_A_XPREV;
      end
      S_A_XPREV: begin
        cmd_o   = mk(ffca_pkg::OP_XPREV);
        state_d = S_A_WRC;
      end
      S_A_WRC: begin
        cmd_o   = mk(ffca_pkg::OP_WR_C);
        state_d = S_A_RDH;
      end
      S_A_RDH: begin
        cmd_o   = mk(ffca_pkg::OP_RD_HINT);
        state_d = S_A_LDH;
      end
      S_A_LDH: begin
        cmd_o   = mk(ffca_pkg::OP_LOAD_HH);
        state_d = S_A_HUPD;
      end
      S_A_HUPD: begin
        cmd_o   = fin(ffca_pkg::OP_HINT_ALLOC, ffca_pkg::ST_OK);
        state_d = S_DONE;
      end
      S_S_MRG: begin
        if (flags_i.rd_free) begin
          cmd_o   = mk(ffca_pkg::OP_MERGE_NX);
          state_d = S_S_MRG2;
        end else begin
          cmd_o   = mk(ffca_pkg::OP_XPREV);
          state_d = S_S_WRN;
        end
      end
      S_S_MRG2: begin
        if (flags_i.nh_hn) begin
          cmd_o   = mk(ffca_pkg::OP_RD_NNEXT);
          state_d = S_S_XPREV;
        end else begin
          state_d = S_S_WRN;
        end
      end
      S_S_XPREV: begin
        cmd_o   = mk(ffca_pkg::OP_XPREV);
        state_d = S_S_WRN;
      end
      S_S_WRN: begin
        cmd_o   = mk(ffca_pkg::OP_WR_N);
        state_d = S_S_WRC;
      end
      S_S_WRC: begin
        cmd_o   = mk(ffca_pkg::OP_WR_C);
        state_d = S_S_HINT;
      end
      S_S_HINT: begin
        cmd_o   = mk(ffca_pkg::OP_RD_HINT);
        state_d = S_S_HUPD;
      end
      S_S_HUPD: begin
        cmd_o   = fin(ffca_pkg::OP_HINT_SHR, ffca_pkg::ST_OK);
        state_d = S_DONE;
      end
      S_F_NXT: begin
        if (flags_i.hc_hn) begin
          cmd_o   = mk(ffca_pkg::OP_RD_CNEXT);
          state_d = S_F_MNX;
        end else begin
          state_d = S_F_PRV;
        end
      end
      S_F_MNX: begin
        if (flags_i.rd_free) begin
          cmd_o   = mk(ffca_pkg::OP_MERGE_CX);
          state_d = S_F_MNX2;
        end else begin
          state_d = S_F_PRV;
        end
      end
      S_F_MNX2: begin
        if (flags_i.hc_hn) begin
          cmd_o   = mk(ffca_pkg::OP_RD_CNEXT);
          state_d = S_F_XPREV;
        end else begin
          state_d = S_F_PRV;
        end
      end
      S_F_XPREV: begin
        cmd_o   = mk(ffca_pkg::OP_XPREV);
        state_d = S_F_PRV;
      end
      S_F_PRV: begin
        if (flags_i.hc_hp) begin
          cmd_o   = mk(ffca_pkg::OP_RD_CPREV);
          state_d = S_F_MPV;
        end else begin
          cmd_o   = fin(ffca_pkg::OP_WR_C, ffca_pkg::ST_OK);
          state_d = S_DONE;
        end
      end
      S_F_MPV: begin
        if (flags_i.rd_free) begin
          cmd_o   = mk(ffca_pkg::OP_MERGE_PC);
          state_d = S_F_WRX;
        end else begin
          cmd_o   = fin(ffca_pkg::OP_WR_C, ffca_pkg::ST_OK);
          state_d = S_DONE;
        end
      end
      S_F_WRX: begin
        if (flags_i.hc_hn) begin
          cmd_o   = mk(ffca_pkg::OP_WR_X);
          state_d = S_F_RDN;
        end else begin
          cmd_o   = fin(ffca_pkg::OP_WR_X, ffca_pkg::ST_OK);
          state_d = S_DONE;
        end
      end
      S_F_RDN: begin
        cmd_o   = mk(ffca_pkg::OP_RD_CNEXT);
        state_d = S_F_XPREV2;
      end
      S_F_XPREV2: begin
        cmd_o   = fin(ffca_pkg::OP_XPREV, ffca_pkg::ST_OK);
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= state_d != S_IDLE;
      done_q  <= state_d == S_DONE;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

FILE: rtl/first_fit_chunk_allocator_top.sv
// Top level of the first-fit chunk allocator.
// After reset the block sweeps its header memory once, one granule per cycle (8192
// granules for a 64 KiB buffer), with busy_o high. A request is taken when start_i is
// high and busy_o low, and exactly one result word follows, shown for one cycle with
// done_o high; the receiver cannot hold it off, and busy_o stays high until that word
// has gone. Each step makes at most one access to the header memory, which has one
// write port and one registered read port; an allocate walks the chunks from the hint
// or from the chain head.
module first_fit_chunk_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] data_offset_i,
  input  logic [15:0] req_size_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] result_offset_o
);

  ffca_pkg::cmd_t   cmd;
  ffca_pkg::flags_t flags;

  ffca_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ffca_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_type_i),
    .data_offset_i   (data_offset_i),
    .req_size_i      (req_size_i),
    .flags_o         (flags),
    .status_o        (status_o),
    .result_offset_o (result_offset_o)
  );

endmodule

FILE: rtl/ffca_checker.sv
// Port-level checks of the chunk allocator, bound to the top level.
module ffca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] result_offset_o
);

  // A result word only appears while a request is in hand.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result word outside a request");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("request taken without going busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o)) else $error("result word repeated");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != 2'(ffca_pkg::ST_OK))) |-> (result_offset_o == 16'd0))
    else $error("offset given with a failing status");

endmodule

bind first_fit_chunk_allocator_top ffca_checker u_ffca_checker (.*);
